// File: design/vcm_pkg.sv
package vcm_pkg;

  localparam int FRAC_BITS = 16;

  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic signed [18:0]   q16_t;
  typedef logic signed [15:0]   q14_t;

  typedef struct packed {
    q16_t red;
    q16_t green;
    q16_t blue;
  } rgb_q16_t;

  typedef enum logic [1:0] {
    MODE_SIMPLE_JET = 2'd0,
    MODE_MATLAB_JET = 2'd1,
    MODE_CUBEHELIX  = 2'd2,
    MODE_WHITE      = 2'd3
  } map_mode_t;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAP_MODE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_LOW  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_HIGH = 2'd2;

  localparam int RANGE_HIGH_RESET = 65535;

  localparam q16_t Q16_ONE  = 19'sd65536;
  localparam q16_t Q16_HALF = 19'sd32768;

  localparam frac_t PHASE_START = 16'd10923;

  localparam q14_t COEF_RED_COS   = -16'sd2435;
  localparam q14_t COEF_RED_SIN   = 16'sd29209;
  localparam q14_t COEF_GREEN_COS = -16'sd4789;
  localparam q14_t COEF_GREEN_SIN = -16'sd14852;
  localparam q14_t COEF_BLUE_COS  = 16'sd32325;

endpackage

// File: design/vcm_sample_if.sv
interface vcm_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

// File: design/vcm_pixel_if.sv
interface vcm_pixel_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red_level;
  logic [CHANNEL_BITS-1:0] green_level;
  logic [CHANNEL_BITS-1:0] blue_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink (input valid, input red_level, input green_level, input blue_level,
                output ready);
endinterface

// File: design/value_to_colour_map.sv
// value_to_colour_map: colors a stream of intensity samples for display.
// samples: valid/ready channel carrying one sample_value word per transfer.
// pixels: valid/ready channel carrying red_level, green_level, blue_level.
// cfg_wr_en/cfg_index/cfg_data write map_mode (0), range_low (1) and
// range_high (2); other indexes are ignored. write only while idle.
// throughput: one word per clock while the skid word is empty. every stage
// holds one item and does one step; the normalizing divider retires one
// quotient bit per stage. stages in order: clamp, subtract, divider, colour
// mapping with sine/cosine rom for cubehelix, clip, scale, output register.
// reset (rst, synchronous): pipeline and output empty, map_mode simple jet,
// range_low 0, range_high 65535 (all ones if narrower).
// stall: the output register plus a one-word skid buffer keep the pipeline
// moving while a pixel waits; samples.ready drops only once the skid word
// is occupied, and the whole pipeline then holds until it drains.
module value_to_colour_map import vcm_pkg::*; #(
  parameter int SAMPLE_BITS      = 16,
  parameter int CHANNEL_BITS     = 8,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0]    cfg_data,
  vcm_sample_if.sink                samples,
  vcm_pixel_if.source               pixels
);

  map_mode_t              map_mode;
  logic [SAMPLE_BITS-1:0] range_low;
  logic [SAMPLE_BITS-1:0] range_high;

  logic     en;
  logic     push;
  logic     frac_valid;
  frac_t    frac;
  logic     shade_valid;
  rgb_q16_t shade_rgb;
  logic     lvl_valid;
  logic [CHANNEL_BITS-1:0] lvl_red, lvl_green, lvl_blue;

  logic                    out_valid;
  logic [CHANNEL_BITS-1:0] out_red, out_green, out_blue;
  logic                    skid_valid;
  logic [CHANNEL_BITS-1:0] skid_red, skid_green, skid_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_mode   <= MODE_SIMPLE_JET;
      range_low  <= '0;
      range_high <= SAMPLE_BITS'(RANGE_HIGH_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MAP_MODE:   map_mode   <= map_mode_t'(cfg_data[1:0]);
        REG_RANGE_LOW:  range_low  <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign en            = !skid_valid;
  assign push          = en && lvl_valid;
  assign samples.ready = en;

  vcm_norm #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (samples.valid),
    .sample   (samples.sample_value),
    .low      (range_low),
    .high     (range_high),
    .out_valid(frac_valid),
    .frac     (frac)
  );

  vcm_shade #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_shade (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (frac_valid),
    .frac     (frac),
    .mode     (map_mode),
    .out_valid(shade_valid),
    .rgb      (shade_rgb)
  );

  vcm_level #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_level (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (shade_valid),
    .rgb      (shade_rgb),
    .out_valid(lvl_valid),
    .red      (lvl_red),
    .green    (lvl_green),
    .blue     (lvl_blue)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pixels.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pixels.ready) begin
      if (skid_valid) begin
        out_red   <= skid_red;
        out_green <= skid_green;
        out_blue  <= skid_blue;
      end else if (push) begin
        out_red   <= lvl_red;
        out_green <= lvl_green;
        out_blue  <= lvl_blue;
      end
    end else if (push) begin
      skid_red   <= lvl_red;
      skid_green <= lvl_green;
      skid_blue  <= lvl_blue;
    end
  end

  assign pixels.valid       = out_valid;
  assign pixels.red_level   = out_red;
  assign pixels.green_level = out_green;
  assign pixels.blue_level  = out_blue;

endmodule

// File: design/vcm_norm.sv
module vcm_norm import vcm_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] low,
  input  logic [SAMPLE_BITS-1:0] high,
  output logic                   out_valid,
  output frac_t                  frac
);

  logic [SAMPLE_BITS-1:0] raised;
  logic [SAMPLE_BITS-1:0] clamped;
  logic [SAMPLE_BITS-1:0] clamp_value;
  logic                   clamp_nonempty;
  logic                   clamp_valid;
  logic [SAMPLE_BITS-1:0] den;

  logic [SAMPLE_BITS-1:0] rem      [FRAC_BITS+1];
  frac_t                  quo      [FRAC_BITS+1];
  logic                   nonempty [FRAC_BITS+1];
  logic                   vld      [FRAC_BITS+1];

  assign raised  = (sample < low) ? low : sample;
  assign clamped = (raised > high) ? high : raised;

  // range width; keeping high and low static while items are in flight is left to the user
  always_ff @(posedge clk) begin
    den <= high - low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_valid <= 1'b0;
      vld[0]      <= 1'b0;
    end else if (en) begin
      clamp_valid <= in_valid;
      vld[0]      <= clamp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clamp_value    <= clamped;
      clamp_nonempty <= high > low;
      rem[0]         <= clamp_value - low;
      quo[0]         <= '0;
      nonempty[0]    <= clamp_nonempty;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    logic [SAMPLE_BITS:0] shifted;
    logic [SAMPLE_BITS:0] diff;
    logic                 fits;

    assign shifted = {rem[i], 1'b0};
    assign fits    = shifted >= {1'b0, den};
    assign diff    = shifted - {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]      <= fits ? diff[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
        quo[i+1]      <= {quo[i][FRAC_BITS-2:0], fits};
        nonempty[i+1] <= nonempty[i];
      end
    end
  end

  assign out_valid = vld[FRAC_BITS];
  assign frac      = nonempty[FRAC_BITS] ? quo[FRAC_BITS] : '0;

endmodule

// File: design/vcm_sine_rom.sv
module vcm_sine_rom import vcm_pkg::*; #(
  parameter int  SINE_TABLE_DEPTH = 256,
  localparam int IDX_BITS         = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                en,
  input  logic [IDX_BITS-1:0] sin_addr,
  input  logic [IDX_BITS-1:0] cos_addr,
  output q14_t                sin_q,
  output q14_t                cos_q
);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef q14_t sine_tab_t [SINE_TABLE_DEPTH];

  // quarter-wave taylor series, folded to a full period
  function automatic sine_tab_t build_tab();
    sine_tab_t         tab;
    longint unsigned   q;
    longint unsigned   quad;
    longint unsigned   rem;
    longint unsigned   r;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint            mag;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      q    = longint'(k) * 4;
      quad = q / SINE_TABLE_DEPTH;
      rem  = q % SINE_TABLE_DEPTH;
      r    = quad[0] ? SINE_TABLE_DEPTH - rem : rem;
      x    = (HALF_PI_Q30 * r) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = ((x * x2) >> 30) / 6;
      sum  = longint'(x) - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      mag    = (sum + 32768) >>> 16;
      tab[k] = q14_t'((quad >= 2) ? -mag : mag);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_tab();

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= SINE_TAB[sin_addr];
      cos_q <= SINE_TAB[cos_addr];
    end
  end

endmodule

// File: design/vcm_shade.sv
module vcm_shade import vcm_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  frac_t     frac,
  input  map_mode_t mode,
  output logic      out_valid,
  output rgb_q16_t  rgb
);

  localparam int IDX_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int PH_W     = FRAC_BITS + IDX_BITS + 1;
  localparam logic [PH_W-1:0]     DEPTH_PH  = PH_W'(SINE_TABLE_DEPTH);
  localparam logic [IDX_BITS:0]   DEPTH_IDX = (IDX_BITS+1)'(SINE_TABLE_DEPTH);
  localparam logic [IDX_BITS:0]   QUARTER   = (IDX_BITS+1)'(SINE_TABLE_DEPTH / 4);

  localparam frac_t EIGHTH_1 = 16'd8192;
  localparam frac_t EIGHTH_2 = 16'd16384;
  localparam frac_t EIGHTH_3 = 16'd24576;
  localparam frac_t EIGHTH_4 = 16'd32768;
  localparam frac_t EIGHTH_5 = 16'd40960;
  localparam frac_t EIGHTH_6 = 16'd49152;
  localparam frac_t EIGHTH_7 = 16'd57344;

  typedef logic signed [29:0] mix_t;
  typedef logic signed [43:0] prod_t;

  typedef struct packed {
    logic [13:0] amp;
    q16_t        base;
    rgb_q16_t    plain;
  } carry_t;

  // 4 * (f - start), with f at or above start
  function automatic q16_t ramp(input frac_t f, input frac_t start);
    return q16_t'({3'b000, frac_t'(f - start)}) <<< 2;
  endfunction

  // round half away from zero, then drop 28 fraction bits
  function automatic q16_t round_q28(input prod_t x);
    prod_t biased;
    biased = x + (x[43] ? 44'sd134217727 : 44'sd134217728);
    return q16_t'(biased >>> 28);
  endfunction

  logic        vld [1:8];
  carry_t      cy  [1:7];

  rgb_q16_t    plain;
  logic [17:0] three_f;
  q16_t        base_c;
  logic [32:0] amp_prod;
  logic [PH_W-1:0] ph_scaled;
  logic [IDX_BITS:0] cos_sum;

  frac_t               phase1;
  logic [IDX_BITS-1:0] idx2;
  logic [IDX_BITS-1:0] sin_addr3;
  logic [IDX_BITS-1:0] cos_addr3;
  q14_t                sn4;
  q14_t                cs4;
  mix_t                p_rc5, p_rs5, p_gc5, p_gs5, p_bc5;
  mix_t                mix_r6, mix_g6, mix_b6;
  prod_t               prod_r7, prod_g7, prod_b7;

  always_comb begin
    plain.red   = Q16_ONE;
    plain.green = Q16_ONE;
    plain.blue  = Q16_ONE;
    case (mode)
      MODE_SIMPLE_JET: begin
        if (frac < EIGHTH_2) begin
          plain.red   = '0;
          plain.green = ramp(frac, '0);
        end else if (frac < EIGHTH_4) begin
          plain.red  = '0;
          plain.blue = Q16_ONE - ramp(frac, EIGHTH_2);
        end else if (frac < EIGHTH_6) begin
          plain.red  = ramp(frac, EIGHTH_4);
          plain.blue = '0;
        end else begin
          plain.green = Q16_ONE - ramp(frac, EIGHTH_6);
          plain.blue  = '0;
        end
      end
      MODE_MATLAB_JET: begin
        if (frac < EIGHTH_1) begin
          plain.blue  = Q16_HALF + ramp(frac, '0);
          plain.green = '0;
          plain.red   = '0;
        end else if (frac < EIGHTH_3) begin
          plain.red   = '0;
          plain.green = ramp(frac, EIGHTH_1);
        end else if (frac < EIGHTH_5) begin
          plain.red  = ramp(frac, EIGHTH_3);
          plain.blue = Q16_ONE - ramp(frac, EIGHTH_3);
        end else if (frac < EIGHTH_7) begin
          plain.green = Q16_ONE - ramp(frac, EIGHTH_5);
          plain.blue  = '0;
        end else begin
          plain.red   = Q16_ONE - ramp(frac, EIGHTH_7);
          plain.green = '0;
          plain.blue  = '0;
        end
      end
      default: begin
        plain.red = Q16_ONE;
      end
    endcase
  end

  assign three_f   = {2'b00, frac} + {1'b0, frac, 1'b0};
  assign base_c    = Q16_ONE - q16_t'({3'b000, frac});
  assign amp_prod  = 33'(frac) * 33'(base_c[16:0]);
  assign ph_scaled = PH_W'(phase1) * DEPTH_PH;
  assign cos_sum   = {1'b0, idx2} + QUARTER;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 8; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[1] <= in_valid;
      for (int k = 2; k <= 8; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cy[1].amp   <= amp_prod[30:17];
      cy[1].base  <= base_c;
      cy[1].plain <= plain;
      for (int k = 2; k <= 7; k++) begin
        cy[k] <= cy[k-1];
      end

      phase1 <= frac_t'(PHASE_START - frac_t'(three_f >> 1));
      idx2   <= ph_scaled[FRAC_BITS+IDX_BITS-1:FRAC_BITS];

      sin_addr3 <= idx2;
      cos_addr3 <= (cos_sum >= DEPTH_IDX) ? IDX_BITS'(cos_sum - DEPTH_IDX)
                                          : cos_sum[IDX_BITS-1:0];

      p_rc5 <= mix_t'(COEF_RED_COS) * mix_t'(cs4);
      p_rs5 <= mix_t'(COEF_RED_SIN) * mix_t'(sn4);
      p_gc5 <= mix_t'(COEF_GREEN_COS) * mix_t'(cs4);
      p_gs5 <= mix_t'(COEF_GREEN_SIN) * mix_t'(sn4);
      p_bc5 <= mix_t'(COEF_BLUE_COS) * mix_t'(cs4);

      mix_r6 <= p_rc5 + p_rs5;
      mix_g6 <= p_gc5 + p_gs5;
      mix_b6 <= p_bc5;

      prod_r7 <= prod_t'($signed({1'b0, cy[6].amp})) * prod_t'(mix_r6);
      prod_g7 <= prod_t'($signed({1'b0, cy[6].amp})) * prod_t'(mix_g6);
      prod_b7 <= prod_t'($signed({1'b0, cy[6].amp})) * prod_t'(mix_b6);

      if (mode == MODE_CUBEHELIX) begin
        rgb.red   <= cy[7].base + round_q28(prod_r7);
        rgb.green <= cy[7].base + round_q28(prod_g7);
        rgb.blue  <= cy[7].base + round_q28(prod_b7);
      end else begin
        rgb <= cy[7].plain;
      end
    end
  end

  vcm_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .en      (en),
    .sin_addr(sin_addr3),
    .cos_addr(cos_addr3),
    .sin_q   (sn4),
    .cos_q   (cs4)
  );

  assign out_valid = vld[8];

endmodule

// File: design/vcm_level.sv
module vcm_level import vcm_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  rgb_q16_t                rgb,
  output logic                    out_valid,
  output logic [CHANNEL_BITS-1:0] red,
  output logic [CHANNEL_BITS-1:0] green,
  output logic [CHANNEL_BITS-1:0] blue
);

  localparam int PROD_W = 17 + CHANNEL_BITS;
  localparam logic [PROD_W-1:0] LEVEL_MAX = PROD_W'({CHANNEL_BITS{1'b1}});
  localparam logic [PROD_W-1:0] ROUND_BIT = PROD_W'(32'd32768);

  function automatic logic [16:0] clip(input q16_t x);
    if (x < 0) begin
      return '0;
    end else if (x > Q16_ONE) begin
      return Q16_ONE[16:0];
    end
    return x[16:0];
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] scale(input logic [16:0] x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * LEVEL_MAX + ROUND_BIT;
    return p[16+CHANNEL_BITS-1:16];
  endfunction

  logic        clip_valid;
  logic [16:0] red_c, green_c, blue_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      clip_valid <= in_valid;
      out_valid  <= clip_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_c   <= clip(rgb.red);
      green_c <= clip(rgb.green);
      blue_c  <= clip(rgb.blue);
      red     <= scale(red_c);
      green   <= scale(green_c);
      blue    <= scale(blue_c);
    end
  end

endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vcm_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int ROM_DEPTH = 256;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [15:0]               cfg_data = '0;

  vcm_sample_if #(.SAMPLE_BITS(16)) sample_ch ();
  vcm_pixel_if #(.CHANNEL_BITS(8))  pixel_ch ();

  value_to_colour_map #(
    .SAMPLE_BITS(16),
    .CHANNEL_BITS(8),
    .SINE_TABLE_DEPTH(ROM_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .samples(sample_ch),
    .pixels(pixel_ch)
  );

  map_mode_t   mode_reg = MODE_SIMPLE_JET;
  logic [15:0] low_reg = 16'd0;
  logic [15:0] high_reg = 16'(RANGE_HIGH_RESET);

  longint      sine_rom_q14 [ROM_DEPTH];
  logic [15:0] sample_backlog [$];
  pixel_t      pixel_expect [$];
  pixel_t      want_px;
  int          fail_count = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          stall_kind = 0;
  int          stall_left = 0;
  int          stall_tick = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // sine rom: quarter wave from a taylor series, mirrored to a full turn
  initial begin
    longint unsigned q, quad, rem, rr, x, x2, term;
    longint sum, mag;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      q = k * 4;
      quad = q / ROM_DEPTH;
      rem = q % ROM_DEPTH;
      rr = quad[0] ? ROM_DEPTH - rem : rem;
      x = (HALF_PI_Q30 * rr) / ROM_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          sum -= longint'(term);
        end else begin
          sum += longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      mag = (sum + 32768) >> 16;
      sine_rom_q14[k] = (quad >= 2) ? -mag : mag;
    end
  end

  function automatic longint round_q28(longint x);
    if (x < 0) begin
      return -(((-x) + 64'sd134217728) >> 28);
    end
    return (x + 64'sd134217728) >> 28;
  endfunction

  function automatic logic [7:0] level_of(longint x);
    if (x < 0) begin
      x = 0;
    end
    if (x > 65536) begin
      x = 65536;
    end
    return 8'((x * 255 + 32768) >> 16);
  endfunction

  function automatic pixel_t colour_of(logic [15:0] v);
    longint unsigned vv, q, ph, idx;
    longint f, r, g, b, amp, base, sn, cs;
    pixel_t px;
    vv = v;
    if (vv < low_reg) begin
      vv = low_reg;
    end
    if (vv > high_reg) begin
      vv = high_reg;
    end
    f = 0;
    if (high_reg > low_reg) begin
      q = ((vv - low_reg) << 16) / (high_reg - low_reg);
      f = (q > 65535) ? 65535 : longint'(q);
    end
    r = 65536;
    g = 65536;
    b = 65536;
    case (mode_reg)
      MODE_SIMPLE_JET: begin
        if (f < 16384) begin
          r = 0; g = 4 * f;
        end else if (f < 32768) begin
          r = 0; b = 65536 - 4 * (f - 16384);
        end else if (f < 49152) begin
          r = 4 * (f - 32768); b = 0;
        end else begin
          g = 65536 - 4 * (f - 49152); b = 0;
        end
      end
      MODE_MATLAB_JET: begin
        if (f < 8192) begin
          b = 32768 + 4 * f; g = 0; r = 0;
        end else if (f < 24576) begin
          r = 0; g = 4 * (f - 8192);
        end else if (f < 40960) begin
          r = 4 * (f - 24576); b = 65536 - 4 * (f - 24576);
        end else if (f < 57344) begin
          g = 65536 - 4 * (f - 40960); b = 0;
        end else begin
          r = 65536 - 4 * (f - 57344); g = 0; b = 0;
        end
      end
      MODE_CUBEHELIX: begin
        ph = (longint'(PHASE_START) + 131072 - ((3 * f) >> 1)) & 65535;
        idx = (ph * ROM_DEPTH) >> 16;
        sn = sine_rom_q14[idx];
        cs = sine_rom_q14[(idx + ROM_DEPTH / 4) % ROM_DEPTH];
        amp = (f * (65536 - f)) >> 17;
        base = 65536 - f;
        r = base + round_q28(amp * (longint'(COEF_RED_COS) * cs + longint'(COEF_RED_SIN) * sn));
        g = base + round_q28(amp * (longint'(COEF_GREEN_COS) * cs
                                    + longint'(COEF_GREEN_SIN) * sn));
        b = base + round_q28(amp * (longint'(COEF_BLUE_COS) * cs));
      end
      default: begin
      end
    endcase
    px.red = level_of(r);
    px.green = level_of(g);
    px.blue = level_of(b);
    return px;
  endfunction

  task automatic report_mismatch(string msg);
    if (fail_count < 50) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        pixel_expect.push_back(colour_of(sample_ch.sample_value));
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          sample_ch.valid <= 1'b0;
        end else if (sample_backlog.size() != 0) begin
          sample_ch.valid <= 1'b1;
          sample_ch.sample_value <= sample_backlog.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      pixel_ch.ready <= 1'b0;
    end else begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        if (pixel_expect.size() == 0) begin
          report_mismatch("pixel word with no sample pending");
        end else begin
          want_px = pixel_expect.pop_front();
          if (pixel_ch.red_level !== want_px.red) begin
            report_mismatch($sformatf("red_level %0d, expected %0d",
                                      pixel_ch.red_level, want_px.red));
          end
          if (pixel_ch.green_level !== want_px.green) begin
            report_mismatch($sformatf("green_level %0d, expected %0d",
                                      pixel_ch.green_level, want_px.green));
          end
          if (pixel_ch.blue_level !== want_px.blue) begin
            report_mismatch($sformatf("blue_level %0d, expected %0d",
                                      pixel_ch.blue_level, want_px.blue));
          end
        end
      end
      if (stall_left == 0) begin
        stall_kind = $urandom_range(0, 2);
        stall_left = $urandom_range(50, 300);
      end
      stall_left--;
      stall_tick++;
      case (stall_kind)
        0: pixel_ch.ready <= 1'b1;
        1: pixel_ch.ready <= ($urandom_range(0, 3) != 0);
        default: pixel_ch.ready <= ((stall_tick % 32) >= 24);
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[15:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_MAP_MODE:   mode_reg = map_mode_t'(data[1:0]);
      REG_RANGE_LOW:  low_reg = data[15:0];
      REG_RANGE_HIGH: high_reg = data[15:0];
      default: begin
      end
    endcase
  endtask

  task automatic configure(input int unsigned mode_bits, input int unsigned lo,
                           input int unsigned hi);
    write_reg(REG_MAP_MODE, mode_bits);
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
  endtask

  task automatic send_words(input int unsigned vals[$]);
    @(negedge clk);
    foreach (vals[i]) begin
      sample_backlog.push_back(vals[i][15:0]);
    end
    do @(negedge clk);
    while (sample_backlog.size() != 0 || sample_ch.valid || pixel_expect.size() != 0);
  endtask

  task automatic random_phase(input int p, input int count);
    int unsigned a, b, lo, hi, mn, mx, v;
    int unsigned words[$];
    a = $urandom_range(0, 65535);
    b = $urandom_range(0, 65535);
    case ($urandom_range(0, 5))
      0: begin
        lo = 0; hi = 65535;
      end
      1: begin
        lo = (a < b) ? a : b; hi = (a < b) ? b : a;
      end
      2: begin
        lo = a; hi = a + $urandom_range(1, 16);
        if (hi > 65535) begin
          hi = 65535;
        end
      end
      3: begin
        lo = a; hi = a;
      end
      4: begin
        lo = (a > b) ? a : b; hi = (a > b) ? b : a;
      end
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          lo = 0; hi = 1;
        end else begin
          lo = 65534; hi = 65535;
        end
      end
    endcase
    configure(($urandom_range(0, 16383) << 2) | (p % 4), lo, hi);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(REG_UNUSED, $urandom_range(0, 65535));
    end
    mn = (lo < hi) ? lo : hi;
    mx = (lo < hi) ? hi : lo;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1: v = $urandom_range(0, 65535);
        2: begin
          case ($urandom_range(0, 5))
            0: v = lo;
            1: v = hi;
            2: v = (mn == 0) ? 0 : mn - 1;
            3: v = (mx == 65535) ? 65535 : mx + 1;
            4: v = 0;
            default: v = 65535;
          endcase
        end
        default: v = $urandom_range(mn, mx);
      endcase
      words.push_back(v);
    end
    send_words(words);
  endtask

  initial begin
    int unsigned words[$];
    sample_ch.valid = 1'b0;
    sample_ch.sample_value = '0;
    pixel_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: simple jet over the full range, segment edges
    words = {0, 16383, 16384, 32768, 49152, 65535};
    send_words(words);

    configure(MODE_MATLAB_JET, 0, 65535);
    words = {8191, 8192, 24576, 40960, 57344};
    send_words(words);

    configure(MODE_CUBEHELIX, 0, 65535);
    words = {0, 21845, 32768, 65535};
    send_words(words);

    // upper bits of the mode word are ignored
    write_reg(REG_MAP_MODE, 16'hFFFF);
    words = {12345};
    send_words(words);

    // empty range
    configure(MODE_CUBEHELIX, 65535, 65535);
    words = {0, 65535};
    send_words(words);

    // inverted bounds
    configure(MODE_SIMPLE_JET, 5000, 100);
    words = {3000, 6000};
    send_words(words);

    // write to an index past the register list
    configure(MODE_SIMPLE_JET, 0, 65535);
    write_reg(REG_UNUSED, 16'h1234);
    words = {20000};
    send_words(words);

    for (int p = 0; p < 12; p++) begin
      random_phase(p, 85);
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
